// ----- hdl/window_at_most_k_distinct_count_macros.svh -----
// ----------------------------------------------------------------------------
// window_at_most_k_distinct_count_macros
// assertion macros used by the block's datapath (wakd_dp)
// ----------------------------------------------------------------------------
`ifndef WINDOW_AT_MOST_K_DISTINCT_COUNT_MACROS_SVH
`define WINDOW_AT_MOST_K_DISTINCT_COUNT_MACROS_SVH

// property that holds at every edge out of reset
`define WAKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define WAKD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/wakd_pkg.sv -----
// ----------------------------------------------------------------------------
// wakd_pkg
// types, commands and defaults of the at-most-k-distinct window counter
// ----------------------------------------------------------------------------
`default_nettype none

package wakd_pkg;

  localparam int DEF_WINDOW_DEPTH   = 1024;
  localparam int DEF_DISTINCT_SLOTS = 16;
  localparam int DEF_VALUE_BITS     = 32;

  localparam int VALUE_W  = 32;
  localparam int TOTAL_W  = 48;
  localparam int WLEN_W   = 11;
  localparam int KMAX_W   = 5;
  localparam logic [KMAX_W-1:0] KMAX_RESET = 5'd1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               first;
  } in_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [WLEN_W-1:0]  window_len;
    logic               overflow;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_FULL,
    S_FULL_DROP,
    S_MATCH,
    S_EVICT_DROP,
    S_APPEND,
    S_TRIM,
    S_TRIM_DROP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_oldest;
    logic drop;
    logic set_ovf;
    logic take_hit;
    logic alloc;
    logic append;
    logic add_total;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic hit;
    logic dist_full;
    logic nonempty;
    logic over_k;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/wakd_ctrl.sv -----
// ----------------------------------------------------------------------------
// wakd_ctrl
// sequencer: store-full (overflow) drop, slot match, eviction drop, append, trim, emit
// ----------------------------------------------------------------------------
`default_nettype none

module wakd_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  wakd_pkg::sts_t   sts,
  output wakd_pkg::cmd_t   cmd
);
  import wakd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:       if (in_valid) state_nxt = S_CHK_FULL;
      S_CHK_FULL:   state_nxt = sts.full ? S_FULL_DROP : S_MATCH;
      S_FULL_DROP:  state_nxt = S_MATCH;
      S_MATCH: begin
        if (sts.hit) state_nxt = S_APPEND;
        else if (sts.dist_full && sts.nonempty) state_nxt = S_EVICT_DROP;
        else state_nxt = S_APPEND;
      end
      S_EVICT_DROP: state_nxt = S_MATCH;
      S_APPEND:     state_nxt = S_TRIM;
      S_TRIM:       state_nxt = (sts.over_k && sts.nonempty) ? S_TRIM_DROP : S_EMIT;
      S_TRIM_DROP:  state_nxt = S_TRIM;
      S_EMIT:       if (out_free) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_CHK_FULL:   cmd.rd_oldest = sts.full;
      S_FULL_DROP: begin
        cmd.drop    = 1'b1;
        cmd.set_ovf = 1'b1;
      end
      S_MATCH: begin
        if (sts.hit) cmd.take_hit = 1'b1;
        else if (sts.dist_full && sts.nonempty) cmd.rd_oldest = 1'b1;
        else cmd.alloc = 1'b1;
      end
      S_EVICT_DROP: cmd.drop = 1'b1;
      S_APPEND:     cmd.append = 1'b1;
      S_TRIM: begin
        if (sts.over_k && sts.nonempty) cmd.rd_oldest = 1'b1;
        else cmd.add_total = 1'b1;
      end
      S_TRIM_DROP:  cmd.drop = 1'b1;
      S_EMIT:       cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

endmodule

`default_nettype wire

// ----- hdl/wakd_dp.sv -----
// ----------------------------------------------------------------------------
// wakd_dp
// window ring store of slot tags, distinct-value slot lanes, counters, total
// ----------------------------------------------------------------------------
`default_nettype none

`include "window_at_most_k_distinct_count_macros.svh"

module wakd_dp #(
  parameter int WINDOW_DEPTH   = wakd_pkg::DEF_WINDOW_DEPTH,
  parameter int DISTINCT_SLOTS = wakd_pkg::DEF_DISTINCT_SLOTS,
  parameter int VALUE_BITS     = wakd_pkg::DEF_VALUE_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_valid,
  input  wire [wakd_pkg::KMAX_W-1:0]   cfg_data,
  input  wakd_pkg::in_t                in_data,
  input  wakd_pkg::cmd_t               cmd,
  output wakd_pkg::sts_t               sts,
  output wakd_pkg::out_t               out_data
);
  import wakd_pkg::*;

  localparam int SW   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int AW   = (WINDOW_DEPTH > 2) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SIW  = (DISTINCT_SLOTS > 1) ? $clog2(DISTINCT_SLOTS) : 1;
  localparam int DW   = $clog2(DISTINCT_SLOTS + 1);
  localparam int KW   = (DW > KMAX_W) ? DW : KMAX_W;

  logic [SIW-1:0]  mem [WINDOW_DEPTH];

  logic [KMAX_W-1:0]        kmax_r;
  logic [SW-1:0]            val_r;
  logic [AW-1:0]            oldest_r;
  logic [CNW-1:0]           count_r;
  logic [DW-1:0]            distinct_r;
  logic [TOTAL_W-1:0]       total_r;
  logic                     ovf_r;
  logic [SIW-1:0]           cur_r;
  logic [SIW-1:0]           rd_r;
  logic [DISTINCT_SLOTS-1:0] slot_vld_r;
  logic [SW-1:0]            slot_val_r [DISTINCT_SLOTS];
  logic [CNW-1:0]           slot_cnt_r [DISTINCT_SLOTS];
  out_t                     out_r;

  logic [DISTINCT_SLOTS-1:0] hit_vec;
  logic [SIW-1:0]           hit_idx;
  logic [SIW-1:0]           free_idx;
  logic                     drop_last;
  logic [AW:0]              pos_sum;
  logic [AW-1:0]            wr_pos;
  logic [AW:0]              oldest_inc;
  logic [TOTAL_W:0]         total_sum;
  logic                     clr;

  assign clr = cmd.accept && in_data.first;

  always_comb begin
    hit_idx   = '0;
    free_idx  = '0;
    drop_last = 1'b0;
    for (int s = 0; s < DISTINCT_SLOTS; s++) begin
      hit_vec[s] = slot_vld_r[s] && (slot_val_r[s] == val_r);
      if (hit_vec[s]) hit_idx = hit_idx | SIW'(s);
      if (rd_r == SIW'(s) && slot_cnt_r[s] == CNW'(1)) drop_last = 1'b1;
    end
    for (int s = DISTINCT_SLOTS - 1; s >= 0; s--) begin
      if (!slot_vld_r[s]) free_idx = SIW'(s);
    end
  end

  assign pos_sum    = {1'b0, oldest_r} + (AW+1)'(count_r);
  assign wr_pos     = (pos_sum >= (AW+1)'(WINDOW_DEPTH)) ?
                      AW'(pos_sum - (AW+1)'(WINDOW_DEPTH)) : AW'(pos_sum);
  assign oldest_inc = {1'b0, oldest_r} + (AW+1)'(1);
  assign total_sum  = {1'b0, total_r} + (TOTAL_W+1)'(count_r);

  assign sts.full      = (count_r == CNW'(WINDOW_DEPTH));
  assign sts.hit       = |hit_vec;
  assign sts.dist_full = (distinct_r == DW'(DISTINCT_SLOTS));
  assign sts.nonempty  = (count_r != '0);
  assign sts.over_k    = (KW'(distinct_r) > KW'(kmax_r));

  always_ff @(posedge clk) begin
    if (cmd.append) mem[wr_pos] <= cur_r;
    if (cmd.rd_oldest) rd_r <= mem[oldest_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmax_r     <= KMAX_RESET;
      oldest_r   <= '0;
      count_r    <= '0;
      distinct_r <= '0;
      total_r    <= '0;
      ovf_r      <= 1'b0;
      slot_vld_r <= '0;
    end else begin
      if (cfg_valid) kmax_r <= cfg_data;
      if (clr) begin
        oldest_r   <= '0;
        count_r    <= '0;
        distinct_r <= '0;
        total_r    <= '0;
        ovf_r      <= 1'b0;
        slot_vld_r <= '0;
      end
      if (cmd.set_ovf) ovf_r <= 1'b1;
      if (cmd.alloc) begin
        distinct_r           <= distinct_r + DW'(1);
        slot_vld_r[free_idx] <= 1'b1;
      end
      if (cmd.append) count_r <= count_r + CNW'(1);
      if (cmd.drop) begin
        count_r  <= count_r - CNW'(1);
        oldest_r <= (oldest_inc == (AW+1)'(WINDOW_DEPTH)) ? '0 : AW'(oldest_inc);
        if (drop_last) begin
          distinct_r       <= distinct_r - DW'(1);
          slot_vld_r[rd_r] <= 1'b0;
        end
      end
      if (cmd.add_total) total_r <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) val_r <= in_data.value[SW-1:0];
    if (cmd.take_hit) cur_r <= hit_idx;
    if (cmd.alloc) cur_r <= free_idx;
    for (int s = 0; s < DISTINCT_SLOTS; s++) begin
      if (cmd.alloc && free_idx == SIW'(s)) begin
        slot_val_r[s] <= val_r;
        slot_cnt_r[s] <= '0;
      end
      if (cmd.append && cur_r == SIW'(s)) slot_cnt_r[s] <= slot_cnt_r[s] + CNW'(1);
      if (cmd.drop && rd_r == SIW'(s)) slot_cnt_r[s] <= slot_cnt_r[s] - CNW'(1);
    end
    if (cmd.load_out) begin
      out_r.total      <= total_r;
      out_r.window_len <= WLEN_W'(count_r);
      out_r.overflow   <= ovf_r;
    end
  end

  assign out_data = out_r;

  `WAKD_ASSERT(a_distinct_matches_valid, distinct_r == DW'($countones(slot_vld_r)), "distinct count out of step with slot valid bits")
  `WAKD_ASSERT(a_count_bound, count_r <= CNW'(WINDOW_DEPTH), "window longer than store")
  `WAKD_ASSERT_IMPL(a_drop_nonempty, cmd.drop, count_r != '0, "drop from empty window")
  `WAKD_ASSERT_IMPL(a_alloc_free, cmd.alloc, !slot_vld_r[free_idx], "allocation of a busy slot")

endmodule

`default_nettype wire

// ----- hdl/window_at_most_k_distinct_count.sv -----
// ----------------------------------------------------------------------------
// window_at_most_k_distinct_count
// running count of subarrays with at most k distinct values over a stream
//
//   channel  dir  payload                          handshake
//   in_      in   value, first                     in_valid / in_ready
//   out_     out  total, window_len, overflow      out_valid / out_ready
//   cfg_     in   max_distinct                     cfg_valid / cfg_ready
//
// after a transaction is accepted, the check-full, match, append and trim steps
// run, then the emit step loads the result and the next one can be taken;
// a store-full drop adds a drop step, a value dropped for the table or the k
// limit adds a read and a drop step (ring store read is registered); each value
// is dropped at most once; a new transaction is taken while the previous result
// waits in the output register; the emit step waits for that register to free up
// rst_n is synchronous; store contents need no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module window_at_most_k_distinct_count #(
  parameter int WINDOW_DEPTH   = wakd_pkg::DEF_WINDOW_DEPTH,
  parameter int DISTINCT_SLOTS = wakd_pkg::DEF_DISTINCT_SLOTS,
  parameter int VALUE_BITS     = wakd_pkg::DEF_VALUE_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wakd_pkg::in_t                in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output wakd_pkg::out_t               out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [wakd_pkg::KMAX_W-1:0]   cfg_data
);
  import wakd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  wakd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wakd_dp #(
    .WINDOW_DEPTH   (WINDOW_DEPTH),
    .DISTINCT_SLOTS (DISTINCT_SLOTS),
    .VALUE_BITS     (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
